@@ hdl/tpe_pkg.sv @@
// shared types and codes for the simplex tableau pivot engine
// no dependencies
package tpe_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FOLD  = 2'd2;
    localparam logic [1:0] OP_ITER  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_PIVOTED   = 2'd1;
    localparam logic [1:0] ST_OPTIMAL   = 2'd2;
    localparam logic [1:0] ST_UNBOUNDED = 2'd3;

    localparam logic CFG_VARS = 1'b0;
    localparam logic CFG_CONS = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ_RD,
        S_READ_DATA,
        S_FOLD_RD,
        S_FOLD_ACC,
        S_FOLD_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RAT_RD,
        S_RAT_CHK,
        S_RAT_MULA,
        S_RAT_MULB,
        S_RAT_CMP,
        S_RAT_END,
        S_PR_RD,
        S_PR_LD,
        S_PR_DIV,
        S_PR_WR,
        S_EL_FRD,
        S_EL_FLD,
        S_EL_RD,
        S_EL_MUL,
        S_EL_RND,
        S_EL_WR,
        S_DONE
    } state_t;

endpackage

@@ hdl/tpe_ram.sv @@
// tableau store: one write port, two registered read ports
// no dependencies
module tpe_ram #(
    parameter int AW = 9,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/tpe_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module tpe_div #(
    parameter int NW = 50,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DW:0]     r_sh;
    logic [DW:0]     r_sub;
    logic            fits;

    assign r_sh  = {rem_reg, q_reg[NW-1]};
    assign r_sub = r_sh - {1'b0, d_reg};
    assign fits  = (r_sh >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNTW'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= r_sub[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r_sh[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/simplex_tableau_pivot_engine.sv @@
// top level: request sequencer, fold, ratio test and pivot datapath
// depends on tpe_pkg, tpe_ram, tpe_div
//
// One request is taken at a time and gives one result; a finished result sits in
// an output register so the next request can be taken while it waits. After reset
// a clearing pass writes the whole store before the first request is taken. A
// write passes through a write state, a read through an address and a data state.
// The phase-one fold walks the C active columns, reads the R active rows of each,
// one store read per step, and writes each column's result back to row 0. An
// iteration scans the objective columns for the first negative entry, runs the
// ratio test on that column (two 32x32 products per later candidate row, in
// separate states) and, if a leaving row is found, divides each column of the
// pivot row with the one-bit-per-cycle divider, then eliminates the pivot column
// from every other row, entry by entry.
module simplex_tableau_pivot_engine #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [3:0]         row_index,
    input  logic [4:0]         col_index,
    input  logic signed [31:0] entry_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [4:0]         entering_col,
    output logic [3:0]         leaving_row,
    output logic               unbounded_flag,
    output logic               overflow_flag
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int AW   = RW + CW;
    localparam int NW   = FRAC_BITS + 34;
    localparam int DVW  = 33;
    localparam int ACCW = 33 + RW;
    localparam logic [31:0] ONE_WORD = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] MAX_V = 64'sd2147483647;
    localparam logic signed [63:0] MIN_V = -64'sd2147483648;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);

    function automatic logic [31:0] sat_word(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > MAX_V)
        begin
            res = MAX_V[31:0];
        end
        else if (v < MIN_V)
        begin
            res = MIN_V[31:0];
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic sat_hit(input logic signed [63:0] v);
        return (v > MAX_V) || (v < MIN_V);
    endfunction

    tpe_pkg::state_t state_reg, state_next;

    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      col_reg;
    logic               addr_ok_reg;
    logic [31:0]        val_reg;
    logic [4:0]         viu_reg;
    logic [3:0]         cir_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [RW:0]        i_reg;
    logic [CW:0]        j_reg;
    logic [CW-1:0]      c_reg;
    logic [RW-1:0]      r_reg;
    logic               found_reg;
    logic signed [31:0] ar_reg, br_reg, ai_reg, bi_reg;
    logic signed [63:0] prod_reg, prod2_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [31:0] f_reg, x_reg;
    logic signed [63:0] d_reg;
    logic               neg_reg;
    logic               unb_reg;
    logic               ov_reg;
    logic [31:0]        rd_reg;
    logic [1:0]         res_status_reg;
    logic [CW-1:0]      res_ent_reg;
    logic [RW-1:0]      res_leave_reg;
    logic               out_valid_reg;
    logic [31:0]        read_value_reg;
    logic [1:0]         status_reg;
    logic [4:0]         entering_col_reg;
    logic [3:0]         leaving_row_reg;
    logic               unbounded_flag_reg;
    logic               overflow_flag_reg;

    logic [RW:0]        rows_last;
    logic [CW:0]        cols_last;
    logic               in_acc;
    logic               out_load;
    logic [RW:0]        k_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [31:0]        rdata_a, rdata_b;
    logic signed [31:0] qa, qb;

    logic               div_start;
    logic [NW-1:0]      div_n;
    logic [DVW-1:0]     div_d;
    logic               div_done;
    logic [NW-1:0]      div_q;
    logic [31:0]        mag_a;

    logic [31:0]        pr_word;
    logic               pr_ov;
    logic signed [63:0] el_diff;
    logic signed [63:0] acc_wide;
    logic [63:0]        pmag, pmag_r;

    tpe_ram #(.AW(AW), .DW(32)) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    tpe_div #(.NW(NW), .DW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign qa = $signed(rdata_a);
    assign qb = $signed(rdata_b);

    always_comb
    begin
        if (32'(cir_reg) > MAX_ROWS - 1)
        begin
            rows_last = (RW+1)'(MAX_ROWS - 1);
        end
        else
        begin
            rows_last = (RW+1)'(cir_reg);
        end
        if (32'(viu_reg) + 32'd1 > MAX_COLS - 1)
        begin
            cols_last = (CW+1)'(MAX_COLS - 1);
        end
        else
        begin
            cols_last = (CW+1)'(32'(viu_reg) + 32'd1);
        end
    end

    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == tpe_pkg::S_DONE) && (!out_valid_reg || out_ready);

    // next row of the elimination, stepping over the pivot row
    always_comb
    begin
        k_next = i_reg + 1'b1;
        if (k_next[RW-1:0] == r_reg && k_next <= rows_last)
        begin
            k_next = k_next + 1'b1;
        end
    end

    // pivot row quotient with saturation
    assign mag_a = qa[31] ? (32'd0 - rdata_a) : rdata_a;
    assign div_n = ((NW'(mag_a) << FRAC_BITS) << 1) + NW'(ar_reg);
    assign div_d = {ar_reg, 1'b0};

    always_comb
    begin
        if (neg_reg)
        begin
            pr_ov   = div_q > NW'(33'h080000000);
            pr_word = pr_ov ? MIN_V[31:0] : (32'd0 - div_q[31:0]);
        end
        else
        begin
            pr_ov   = div_q > NW'(32'h7fffffff);
            pr_word = pr_ov ? MAX_V[31:0] : div_q[31:0];
        end
    end

    assign el_diff  = 64'(x_reg) - d_reg;
    assign acc_wide = 64'(acc_reg);
    assign pmag     = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
    assign pmag_r   = (pmag + HALF_LSB) >> FRAC_BITS;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpe_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = tpe_pkg::S_IDLE;
                end
            end
            tpe_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        tpe_pkg::OP_WRITE: state_next = tpe_pkg::S_WRITE;
                        tpe_pkg::OP_READ:  state_next = tpe_pkg::S_READ_RD;
                        tpe_pkg::OP_FOLD:  state_next = tpe_pkg::S_FOLD_RD;
                        default:           state_next = tpe_pkg::S_SCAN_RD;
                    endcase
                end
            end
            tpe_pkg::S_WRITE:     state_next = tpe_pkg::S_DONE;
            tpe_pkg::S_READ_RD:   state_next = tpe_pkg::S_READ_DATA;
            tpe_pkg::S_READ_DATA: state_next = tpe_pkg::S_DONE;
            tpe_pkg::S_FOLD_RD:   state_next = tpe_pkg::S_FOLD_ACC;
            tpe_pkg::S_FOLD_ACC:
            begin
                state_next = (i_reg == rows_last) ? tpe_pkg::S_FOLD_WR : tpe_pkg::S_FOLD_RD;
            end
            tpe_pkg::S_FOLD_WR:
            begin
                state_next = (j_reg == cols_last) ? tpe_pkg::S_DONE : tpe_pkg::S_FOLD_RD;
            end
            tpe_pkg::S_SCAN_RD:
            begin
                state_next = (j_reg >= cols_last) ? tpe_pkg::S_DONE : tpe_pkg::S_SCAN_CHK;
            end
            tpe_pkg::S_SCAN_CHK:
            begin
                state_next = qa[31] ? tpe_pkg::S_RAT_RD : tpe_pkg::S_SCAN_RD;
            end
            tpe_pkg::S_RAT_RD:
            begin
                state_next = (i_reg > rows_last) ? tpe_pkg::S_RAT_END : tpe_pkg::S_RAT_CHK;
            end
            tpe_pkg::S_RAT_CHK:
            begin
                if (!qa[31] && qa != 32'sd0 && found_reg)
                begin
                    state_next = tpe_pkg::S_RAT_MULA;
                end
                else
                begin
                    state_next = tpe_pkg::S_RAT_RD;
                end
            end
            tpe_pkg::S_RAT_MULA: state_next = tpe_pkg::S_RAT_MULB;
            tpe_pkg::S_RAT_MULB: state_next = tpe_pkg::S_RAT_CMP;
            tpe_pkg::S_RAT_CMP:  state_next = tpe_pkg::S_RAT_RD;
            tpe_pkg::S_RAT_END:
            begin
                state_next = found_reg ? tpe_pkg::S_PR_RD : tpe_pkg::S_DONE;
            end
            tpe_pkg::S_PR_RD: state_next = tpe_pkg::S_PR_LD;
            tpe_pkg::S_PR_LD: state_next = tpe_pkg::S_PR_DIV;
            tpe_pkg::S_PR_DIV:
            begin
                if (div_done)
                begin
                    state_next = tpe_pkg::S_PR_WR;
                end
            end
            tpe_pkg::S_PR_WR:
            begin
                state_next = (j_reg == cols_last) ? tpe_pkg::S_EL_FRD : tpe_pkg::S_PR_RD;
            end
            tpe_pkg::S_EL_FRD: state_next = tpe_pkg::S_EL_FLD;
            tpe_pkg::S_EL_FLD: state_next = tpe_pkg::S_EL_RD;
            tpe_pkg::S_EL_RD:  state_next = tpe_pkg::S_EL_MUL;
            tpe_pkg::S_EL_MUL: state_next = tpe_pkg::S_EL_RND;
            tpe_pkg::S_EL_RND: state_next = tpe_pkg::S_EL_WR;
            tpe_pkg::S_EL_WR:
            begin
                if (j_reg != cols_last)
                begin
                    state_next = tpe_pkg::S_EL_RD;
                end
                else if (k_next > rows_last)
                begin
                    state_next = tpe_pkg::S_DONE;
                end
                else
                begin
                    state_next = tpe_pkg::S_EL_FRD;
                end
            end
            tpe_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = tpe_pkg::S_IDLE;
                end
            end
            default: state_next = tpe_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {row_reg, col_reg};
        ram_wdata = val_reg;
        raddr_a   = {row_reg, col_reg};
        raddr_b   = {r_reg, j_reg[CW-1:0]};
        div_start = 1'b0;
        unique case (state_reg)
            tpe_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = (clr_addr_reg == '0) ? ONE_WORD : 32'd0;
            end
            tpe_pkg::S_IDLE: in_ready = 1'b1;
            tpe_pkg::S_WRITE: ram_we = addr_ok_reg;
            tpe_pkg::S_FOLD_RD: raddr_a = {i_reg[RW-1:0], j_reg[CW-1:0]};
            tpe_pkg::S_FOLD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {{RW{1'b0}}, j_reg[CW-1:0]};
                ram_wdata = sat_word(acc_wide);
            end
            tpe_pkg::S_SCAN_RD: raddr_a = {{RW{1'b0}}, j_reg[CW-1:0]};
            tpe_pkg::S_RAT_RD:
            begin
                raddr_a = {i_reg[RW-1:0], c_reg};
                raddr_b = {i_reg[RW-1:0], cols_last[CW-1:0]};
            end
            tpe_pkg::S_PR_RD: raddr_a = {r_reg, j_reg[CW-1:0]};
            tpe_pkg::S_PR_LD: div_start = 1'b1;
            tpe_pkg::S_PR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {r_reg, j_reg[CW-1:0]};
                ram_wdata = pr_word;
            end
            tpe_pkg::S_EL_FRD: raddr_a = {i_reg[RW-1:0], c_reg};
            tpe_pkg::S_EL_RD:
            begin
                raddr_a = {i_reg[RW-1:0], j_reg[CW-1:0]};
                raddr_b = {r_reg, j_reg[CW-1:0]};
            end
            tpe_pkg::S_EL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {i_reg[RW-1:0], j_reg[CW-1:0]};
                ram_wdata = sat_word(el_diff);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= tpe_pkg::S_CLEAR;
            clr_addr_reg       <= '0;
            viu_reg            <= 5'd1;
            cir_reg            <= 4'd1;
            unb_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tpe_pkg::S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tpe_pkg::CFG_VARS: viu_reg <= cfg_wdata;
                    tpe_pkg::CFG_CONS: cir_reg <= cfg_wdata[3:0];
                    default:           viu_reg <= viu_reg;
                endcase
            end
            if (state_reg == tpe_pkg::S_RAT_END && !found_reg)
            begin
                unb_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tpe_pkg::S_IDLE:
            begin
                row_reg        <= RW'(row_index);
                col_reg        <= CW'(col_index);
                addr_ok_reg    <= (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
                val_reg        <= entry_value;
                rd_reg         <= 32'd0;
                ov_reg         <= 1'b0;
                res_status_reg <= tpe_pkg::ST_DONE;
                res_ent_reg    <= '0;
                res_leave_reg  <= '0;
                found_reg      <= 1'b0;
                i_reg          <= (op == tpe_pkg::OP_ITER) ? (RW+1)'(1) : '0;
                j_reg          <= (op == tpe_pkg::OP_ITER) ? (CW+1)'(1) : '0;
            end
            tpe_pkg::S_READ_DATA:
            begin
                rd_reg <= addr_ok_reg ? rdata_a : 32'd0;
            end
            tpe_pkg::S_FOLD_ACC:
            begin
                if (i_reg == '0)
                begin
                    acc_reg <= ACCW'(qa);
                end
                else
                begin
                    acc_reg <= acc_reg - ACCW'(qa);
                end
                i_reg <= i_reg + 1'b1;
            end
            tpe_pkg::S_FOLD_WR:
            begin
                ov_reg <= ov_reg | sat_hit(acc_wide);
                i_reg  <= '0;
                j_reg  <= j_reg + 1'b1;
            end
            tpe_pkg::S_SCAN_RD:
            begin
                if (j_reg >= cols_last)
                begin
                    res_status_reg <= tpe_pkg::ST_OPTIMAL;
                end
            end
            tpe_pkg::S_SCAN_CHK:
            begin
                if (qa[31])
                begin
                    c_reg       <= j_reg[CW-1:0];
                    res_ent_reg <= j_reg[CW-1:0];
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            tpe_pkg::S_RAT_CHK:
            begin
                ai_reg <= qa;
                bi_reg <= qb;
                if (!qa[31] && qa != 32'sd0 && !found_reg)
                begin
                    found_reg <= 1'b1;
                    r_reg     <= i_reg[RW-1:0];
                    ar_reg    <= qa;
                    br_reg    <= qb;
                end
                if (!(!qa[31] && qa != 32'sd0 && found_reg))
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            tpe_pkg::S_RAT_MULA: prod_reg  <= bi_reg * ar_reg;
            tpe_pkg::S_RAT_MULB: prod2_reg <= br_reg * ai_reg;
            tpe_pkg::S_RAT_CMP:
            begin
                if (prod_reg < prod2_reg)
                begin
                    r_reg  <= i_reg[RW-1:0];
                    ar_reg <= ai_reg;
                    br_reg <= bi_reg;
                end
                i_reg <= i_reg + 1'b1;
            end
            tpe_pkg::S_RAT_END:
            begin
                j_reg <= '0;
                if (found_reg)
                begin
                    res_status_reg <= tpe_pkg::ST_PIVOTED;
                    res_leave_reg  <= r_reg;
                end
                else
                begin
                    res_status_reg <= tpe_pkg::ST_UNBOUNDED;
                end
            end
            tpe_pkg::S_PR_LD: neg_reg <= qa[31];
            tpe_pkg::S_PR_WR:
            begin
                ov_reg <= ov_reg | pr_ov;
                if (j_reg == cols_last)
                begin
                    i_reg <= (r_reg == '0) ? (RW+1)'(1) : '0;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            tpe_pkg::S_EL_FLD:
            begin
                f_reg <= qa;
                j_reg <= '0;
            end
            tpe_pkg::S_EL_MUL:
            begin
                prod_reg <= f_reg * qb;
                x_reg    <= qa;
            end
            tpe_pkg::S_EL_RND:
            begin
                d_reg <= prod_reg[63] ? $signed(64'd0 - pmag_r) : $signed(pmag_r);
            end
            tpe_pkg::S_EL_WR:
            begin
                ov_reg <= ov_reg | sat_hit(el_diff);
                if (j_reg == cols_last)
                begin
                    i_reg <= k_next;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_value_reg     <= rd_reg;
            status_reg         <= res_status_reg;
            entering_col_reg   <= 5'(res_ent_reg);
            leaving_row_reg    <= 4'(res_leave_reg);
            unbounded_flag_reg <= unb_reg;
            overflow_flag_reg  <= ov_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = $signed(read_value_reg);
    assign status         = status_reg;
    assign entering_col   = entering_col_reg;
    assign leaving_row    = leaving_row_reg;
    assign unbounded_flag = unbounded_flag_reg;
    assign overflow_flag  = overflow_flag_reg;

    // no request is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpe_pkg::S_CLEAR) |-> !in_ready)
        else $error("request taken during clearing pass");

    // the unbounded mark never falls back
    a_unb_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        unb_reg |=> unb_reg)
        else $error("unbounded mark cleared");

    // elimination never rewrites the pivot row
    a_el_not_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpe_pkg::S_EL_WR) |-> (i_reg[RW-1:0] != r_reg))
        else $error("elimination wrote the pivot row");

    // the divisor always comes from a positive pivot
    a_pivot_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpe_pkg::S_PR_LD) |-> (found_reg && ar_reg > 32'sd0))
        else $error("pivot element not positive");

endmodule

@@ test/tb.sv @@
// self-checking testbench for simplex_tableau_pivot_engine
// depends on tpe_pkg and the engine rtl; a scoreboard class predicts each result
module tb;

    localparam int ROWS = 16;
    localparam int COLS = 32;
    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         entering_col;
        logic [3:0]         leaving_row;
        logic               unbounded_flag;
        logic               overflow_flag;
    } pivot_outcome_t;

    class tableau_scoreboard;
        int             tab [ROWS][COLS];
        bit             unbounded_mark;
        int             vars_n;
        int             cons_n;
        int             errors;
        pivot_outcome_t outcomes [$];

        function new();
            foreach (tab[i, j]) tab[i][j] = 0;
            tab[0][0] = 1 << FRAC;
            unbounded_mark = 0;
            vars_n = 1;
            cons_n = 1;
            errors = 0;
        endfunction

        function void set_cfg(logic idx, int value);
            if (idx == tpe_pkg::CFG_VARS) vars_n = value & 31;
            else cons_n = value & 15;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function int sat32(longint x, inout bit ov);
            if (x > 64'sd2147483647) begin
                ov = 1;
                return 32'h7fffffff;
            end
            if (x < -64'sd2147483648) begin
                ov = 1;
                return 32'h80000000;
            end
            return int'(x);
        endfunction

        function longint round_shift(longint prod);
            longint unsigned mag;
            mag = prod < 0 ? longint'(-prod) : prod;
            mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
            return prod < 0 ? -longint'(mag) : longint'(mag);
        endfunction

        function longint qdiv(int a, int p);
            longint unsigned mag;
            longint unsigned num;
            longint unsigned den;
            longint unsigned q;
            mag = a < 0 ? longint'(-longint'(a)) : longint'(a);
            num = mag << FRAC;
            den = longint'(p);
            q = (2 * num + den) / (2 * den);
            return a < 0 ? -longint'(q) : longint'(q);
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] r, logic [4:0] c,
                                   logic signed [31:0] v);
            pivot_outcome_t e;
            int nr;
            int nc;
            int rhs;
            int col;
            int row;
            int piv;
            int f;
            int newrow [COLS];
            longint acc;
            bit ov;
            e = '{default: 0};
            ov = 0;
            nr = cons_n + 1 > ROWS ? ROWS : cons_n + 1;
            nc = vars_n + 2 > COLS ? COLS : vars_n + 2;
            rhs = nc - 1;
            case (op)
                tpe_pkg::OP_WRITE: tab[r][c] = v;
                tpe_pkg::OP_READ:  e.read_value = tab[r][c];
                tpe_pkg::OP_FOLD:
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = tab[0][j];
                        for (int i = 1; i < nr; i++) acc -= tab[i][j];
                        tab[0][j] = sat32(acc, ov);
                    end
                end
                default:
                begin
                    col = 0;
                    for (int j = 1; j < rhs; j++)
                        if (col == 0 && tab[0][j] < 0) col = j;
                    if (col == 0) e.status = tpe_pkg::ST_OPTIMAL;
                    else
                    begin
                        e.entering_col = 5'(col);
                        row = 0;
                        for (int i = 1; i < nr; i++)
                            if (tab[i][col] > 0)
                                if (row == 0 || longint'(tab[i][rhs]) * longint'(tab[row][col])
                                        < longint'(tab[row][rhs]) * longint'(tab[i][col]))
                                    row = i;
                        if (row == 0)
                        begin
                            unbounded_mark = 1;
                            e.status = tpe_pkg::ST_UNBOUNDED;
                        end
                        else
                        begin
                            piv = tab[row][col];
                            e.leaving_row = 4'(row);
                            e.status = tpe_pkg::ST_PIVOTED;
                            for (int j = 0; j < nc; j++)
                                newrow[j] = sat32(qdiv(tab[row][j], piv), ov);
                            for (int k = 0; k < nr; k++)
                                if (k != row)
                                begin
                                    f = tab[k][col];
                                    for (int j = 0; j < nc; j++)
                                        tab[k][j] = sat32(longint'(tab[k][j])
                                            - round_shift(longint'(f) * longint'(newrow[j])), ov);
                                end
                            for (int j = 0; j < nc; j++) tab[row][j] = newrow[j];
                        end
                    end
                end
            endcase
            e.unbounded_flag = unbounded_mark;
            e.overflow_flag = ov;
            outcomes.insert(outcomes.size(), e);
        endfunction

        function void check_result(pivot_outcome_t got);
            pivot_outcome_t e;
            if (outcomes.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = outcomes.pop_front();
            if (got.read_value !== e.read_value)
            begin
                $error("read_value expected %0d got %0d", e.read_value, got.read_value);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status expected %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.entering_col !== e.entering_col)
            begin
                $error("entering_col expected %0d got %0d", e.entering_col, got.entering_col);
                errors++;
            end
            if (got.leaving_row !== e.leaving_row)
            begin
                $error("leaving_row expected %0d got %0d", e.leaving_row, got.leaving_row);
                errors++;
            end
            if (got.unbounded_flag !== e.unbounded_flag)
            begin
                $error("unbounded_flag expected %0d got %0d", e.unbounded_flag,
                       got.unbounded_flag);
                errors++;
            end
            if (got.overflow_flag !== e.overflow_flag)
            begin
                $error("overflow_flag expected %0d got %0d", e.overflow_flag, got.overflow_flag);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [4:0]         cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic [3:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] entry_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         entering_col;
    logic [3:0]         leaving_row;
    logic               unbounded_flag;
    logic               overflow_flag;

    tableau_scoreboard sb;
    bit calm;
    int sent;
    int idle_cycles = 0;

    simplex_tableau_pivot_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_value(read_value), .status(status), .entering_col(entering_col),
        .leaving_row(leaving_row), .unbounded_flag(unbounded_flag),
        .overflow_flag(overflow_flag)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(logic [1:0] o, int r, int c, int v);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1;
        op <= o;
        row_index <= 4'(r);
        col_index <= 5'(c);
        entry_value <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_request(o, 4'(r), 5'(c), v);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic set_register(logic idx, int value);
        drain();
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= 5'(value);
        @(posedge clk);
        cfg_we <= 0;
        sb.set_cfg(idx, value);
    endtask

    function automatic int small_q(bit positive);
        int v;
        v = ($urandom_range(0, 6) << FRAC) + ($urandom_range(0, 3) << (FRAC - 2));
        if ($urandom_range(0, 15) == 0) return $urandom;
        return positive ? v : -v;
    endfunction

    // well-formed problem load, then iterations with reads and noise mixed in
    task automatic run_problem(int nv, int ncons, int iters);
        for (int r = 0; r <= ncons; r++)
            for (int c = 0; c <= nv + 1; c++)
            begin
                if (r == 0)
                    send_request(tpe_pkg::OP_WRITE, r, c, c == 0 ? 1 << FRAC : small_q(0));
                else
                    send_request(tpe_pkg::OP_WRITE, r, c,
                                 c == 0 ? 0 : small_q($urandom_range(0, 5) != 0));
            end
        if ($urandom_range(0, 3) == 0) send_request(tpe_pkg::OP_FOLD, 0, 0, 0);
        for (int n = 0; n < iters; n++)
        begin
            send_request(tpe_pkg::OP_ITER, 0, 0, $urandom);
            case ($urandom_range(0, 5))
                0: send_request(tpe_pkg::OP_READ, $urandom_range(0, 15),
                                $urandom_range(0, 31), 0);
                1: send_request(tpe_pkg::OP_WRITE, $urandom_range(0, 15),
                                $urandom_range(0, 31), $urandom);
                2: send_request(tpe_pkg::OP_FOLD, $urandom, $urandom, $urandom);
                default: send_request(tpe_pkg::OP_READ, $urandom_range(0, ncons),
                                      $urandom_range(0, nv + 1), $urandom);
            endcase
        end
    endtask

    // receiver: random bursts of back-pressure plus one long hold-off
    initial
    begin
        int idle_left;
        int seen;
        bit held;
        pivot_outcome_t got;
        idle_left = 0;
        seen = 0;
        held = 0;
        out_ready <= 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.read_value = read_value;
                got.status = status;
                got.entering_col = entering_col;
                got.leaving_row = leaving_row;
                got.unbounded_flag = unbounded_flag;
                got.overflow_flag = overflow_flag;
                sb.check_result(got);
                seen++;
            end
            if (idle_left > 0)
            begin
                idle_left--;
                out_ready <= 0;
            end
            else if (!held && seen >= 60)
            begin
                held = 1;
                idle_left = 400;
                out_ready <= 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                idle_left = $urandom_range(0, 3);
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int nv;
        int ncons;
        sb = new();
        calm = 0;
        sent = 0;
        rst_n <= 0;
        cfg_we <= 0;
        cfg_index <= 0;
        cfg_wdata <= 0;
        in_valid <= 0;
        op <= 0;
        row_index <= 0;
        col_index <= 0;
        entry_value <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: small problem with a ratio tie, optimum, fold, overflow, unbounded
        send_request(tpe_pkg::OP_READ, 0, 0, 0);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        set_register(tpe_pkg::CFG_VARS, 2);
        set_register(tpe_pkg::CFG_CONS, 2);
        send_request(tpe_pkg::OP_WRITE, 0, 1, -3 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 0, 2, -2 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 1, 1, 1 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 1, 2, 1 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 1, 3, 4 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 2, 1, 2 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 2, 2, 1 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 2, 3, 8 << FRAC);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        send_request(tpe_pkg::OP_READ, 0, 3, 0);
        send_request(tpe_pkg::OP_WRITE, 15, 31, 32'h80000000);
        send_request(tpe_pkg::OP_READ, 15, 31, 32'h7fffffff);
        send_request(tpe_pkg::OP_WRITE, 0, 1, -1 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 1, 1, 1);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        send_request(tpe_pkg::OP_WRITE, 0, 2, -1 << FRAC);
        send_request(tpe_pkg::OP_WRITE, 1, 2, 0);
        send_request(tpe_pkg::OP_WRITE, 2, 2, -5 << FRAC);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);
        send_request(tpe_pkg::OP_WRITE, 1, 0, 32'h80000000);
        send_request(tpe_pkg::OP_FOLD, 0, 0, 0);
        send_request(tpe_pkg::OP_ITER, 0, 0, 0);

        // random phases: extremes first, then mostly small tableaux
        set_register(tpe_pkg::CFG_VARS, 30);
        set_register(tpe_pkg::CFG_CONS, 15);
        run_problem(30, 15, 4);
        set_register(tpe_pkg::CFG_VARS, 1);
        set_register(tpe_pkg::CFG_CONS, 1);
        run_problem(1, 1, 6);
        set_register(tpe_pkg::CFG_VARS, 30);
        set_register(tpe_pkg::CFG_CONS, 1);
        run_problem(30, 1, 6);
        while (sent < RANDOM_ITEMS + 25)
        begin
            nv = $urandom_range(1, 6);
            ncons = $urandom_range(1, 4);
            if ($urandom_range(0, 5) == 0) ncons = 15;
            set_register(tpe_pkg::CFG_VARS, nv);
            set_register(tpe_pkg::CFG_CONS, ncons);
            if (sent > RANDOM_ITEMS - 100) calm = 1;
            run_problem(nv, ncons, $urandom_range(2, nv + 3));
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
